// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion that is disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/mchq_pkg.sv =====
// package with hull sizes, line entry type and value limits
package mchq_pkg;
  localparam int HULL_DEPTH = 4096;
  localparam int IDX_W = $clog2(HULL_DEPTH);
  localparam int CNT_W = $clog2(HULL_DEPTH + 1);
  localparam int SLOPE_W = 32;
  localparam int VAL_W = 63;
  localparam int PROD_W = VAL_W + SLOPE_W;
  localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic [SLOPE_W-1:0] slope;
    logic [VAL_W-1:0]   icpt;
  } line_t;
endpackage

// ===== hdl/mchq_if.sv =====
// item channel interfaces for the hull engine
interface mchq_req_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [31:0] slope;
  logic [31:0] query_x;
  modport source (output valid, start_req, slope, query_x, input ready);
  modport sink (input valid, start_req, slope, query_x, output ready);
endinterface

interface mchq_rsp_if;
  logic        valid;
  logic        ready;
  logic [62:0] min_value;
  logic        hull_full;
  modport source (output valid, min_value, hull_full, input ready);
  modport sink (input valid, min_value, hull_full, output ready);
endinterface

// ===== hdl/monotone_convex_hull_min_query.sv =====
// a start item loads the first line and gives no result; a query item reads,
// multiplies and adds per line visited at the front, then per pop test reads,
// takes differences, multiplies and compares, then inserts; an empty hull query
// goes straight to the insert, which waits while an earlier result is held by
// the sink; one item at a time, set by the single line memory and the shared
// 32x32 multiplier; reset (synchronous) empties the hull, memory is not cleared
module monotone_convex_hull_min_query import mchq_pkg::*; (
  input logic clk,
  input logic rst,
  mchq_req_if.sink req,
  mchq_rsp_if.source rsp
);
  typedef enum logic [3:0] {
    S_IDLE, S_QRD, S_QMUL, S_QADD, S_PRD, S_PDIFF, S_PMUL, S_PCMP, S_INS
  } state_t;

  state_t state;
  line_t mem [HULL_DEPTH];
  line_t rd_a, rd_b;
  logic [IDX_W-1:0] addr_a, addr_b, qi, front;
  logic [CNT_W-1:0] count;
  logic rd_en, first;
  logic [SLOPE_W-1:0] s_reg, x_reg;
  logic [VAL_W-1:0] best, cin;
  logic [63:0] mp;
  logic [VAL_W-1:0] ma, md;
  logic [SLOPE_W-1:0] mb, me;
  logic na, nb, nd, ne;
  logic [PROD_W-1:0] lhs, rhs;
  logic [2:0] mstep;
  logic [31:0] mul_a, mul_b;
  logic [64:0] sum;
  logic [VAL_W-1:0] v;
  logic lneg, rneg, pop;
  logic [CNT_W-1:0] cnt_m1, cnt_m2;

  assign req.ready = (state == S_IDLE);
  assign cnt_m1 = count - CNT_W'(1);
  assign cnt_m2 = count - CNT_W'(2);

  always_comb begin
    rd_en = 1'b0;
    addr_a = qi;
    addr_b = cnt_m2[IDX_W-1:0];
    if (state == S_QRD) begin
      rd_en = 1'b1;
    end else if (state == S_PRD) begin
      rd_en = 1'b1;
      addr_a = cnt_m1[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a <= mem[addr_a];
      rd_b <= mem[addr_b];
    end
    if (state == S_IDLE && req.valid && req.start_req) begin
      mem[0] <= '{slope: req.slope, icpt: '0};
    end else if (state == S_INS && !(rsp.valid && !rsp.ready) && count < CNT_W'(HULL_DEPTH)) begin
      mem[count[IDX_W-1:0]] <= '{slope: s_reg, icpt: best};
    end
  end

  // shared multiplier operand select
  always_comb begin
    if (state == S_QMUL) begin
      mul_a = rd_a.slope;
      mul_b = x_reg;
    end else begin
      unique case (mstep)
        3'd0: begin mul_a = ma[31:0]; mul_b = mb; end
        3'd1: begin mul_a = {1'b0, ma[62:32]}; mul_b = mb; end
        3'd2: begin mul_a = md[31:0]; mul_b = me; end
        3'd3: begin mul_a = {1'b0, md[62:32]}; mul_b = me; end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  // saturated line value
  assign sum = {1'b0, mp} + {2'b0, cin};
  assign v = (sum > {2'b0, VAL_MAX}) ? VAL_MAX : sum[VAL_W-1:0];

  assign lneg = (na ^ nb) && (lhs != '0);
  assign rneg = (nd ^ ne) && (rhs != '0);
  always_comb begin
    if (lneg != rneg) pop = lneg;
    else if (!lneg) pop = lhs < rhs;
    else pop = rhs < lhs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      front <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (rsp.valid && rsp.ready && state != S_INS) rsp.valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            s_reg <= req.slope;
            x_reg <= req.query_x;
            if (req.start_req) begin
              count <= CNT_W'(1);
              front <= '0;
            end else if (count == '0) begin
              best <= '0;
              state <= S_INS;
            end else begin
              qi <= front;
              first <= 1'b1;
              state <= S_QRD;
            end
          end
        end
        S_QRD: state <= S_QMUL;
        S_QMUL: begin
          mp <= 64'(mul_a) * 64'(mul_b);
          cin <= rd_a.icpt;
          state <= S_QADD;
        end
        S_QADD: begin
          first <= 1'b0;
          if (first || v < best) begin
            best <= v;
            front <= qi;
            if ({1'b0, qi} + CNT_W'(1) < count) begin
              qi <= qi + IDX_W'(1);
              state <= S_QRD;
            end else begin
              state <= S_PRD;
            end
          end else begin
            state <= S_PRD;
          end
        end
        S_PRD: begin
          if (count >= CNT_W'(2) && (count - {1'b0, front}) >= CNT_W'(2)) state <= S_PDIFF;
          else state <= S_INS;
        end
        S_PDIFF: begin
          // rd_a is the last line, rd_b the second-last
          na <= best < rd_b.icpt;
          ma <= (best < rd_b.icpt) ? rd_b.icpt - best : best - rd_b.icpt;
          nb <= rd_b.slope < rd_a.slope;
          mb <= (rd_b.slope < rd_a.slope) ? rd_a.slope - rd_b.slope : rd_b.slope - rd_a.slope;
          nd <= rd_a.icpt < rd_b.icpt;
          md <= (rd_a.icpt < rd_b.icpt) ? rd_b.icpt - rd_a.icpt : rd_a.icpt - rd_b.icpt;
          ne <= rd_b.slope < s_reg;
          me <= (rd_b.slope < s_reg) ? s_reg - rd_b.slope : rd_b.slope - s_reg;
          mstep <= '0;
          state <= S_PMUL;
        end
        S_PMUL: begin
          mp <= 64'(mul_a) * 64'(mul_b);
          mstep <= mstep + 3'd1;
          unique case (mstep)
            3'd1: lhs <= PROD_W'(mp);
            3'd2: lhs <= lhs + {mp[VAL_W-1:0], 32'b0};
            3'd3: rhs <= PROD_W'(mp);
            3'd4: begin
              rhs <= rhs + {mp[VAL_W-1:0], 32'b0};
              state <= S_PCMP;
            end
            default: ;
          endcase
        end
        S_PCMP: begin
          if (pop) begin
            count <= count - CNT_W'(1);
            state <= S_PRD;
          end else begin
            state <= S_INS;
          end
        end
        S_INS: begin
          if (!(rsp.valid && !rsp.ready)) begin
            rsp.valid <= 1'b1;
            rsp.min_value <= best;
            rsp.hull_full <= (count >= CNT_W'(HULL_DEPTH));
            if (count < CNT_W'(HULL_DEPTH)) count <= count + CNT_W'(1);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/mchq_checker.sv =====
// port-level checker for the hull engine, bound to the engine module
`include "assert_macros.svh"
module mchq_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_start,
  input logic        out_valid,
  input logic        out_ready,
  input logic [62:0] out_min,
  input logic        out_full
);
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `ASSERT_CLK(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_min) && $stable(out_full), "result changed while stalled")
  `ASSERT_CLK(a_start_silent, clk, rst, in_valid && in_ready && in_start && !out_valid |=> !out_valid, "start item gave a result")
  `ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !out_valid, "result right after reset")
endmodule

bind monotone_convex_hull_min_query mchq_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready), .in_start(req.start_req),
  .out_valid(rsp.valid), .out_ready(rsp.ready),
  .out_min(rsp.min_value), .out_full(rsp.hull_full)
);
